### rtl/suset_pkg.sv
// ============================================================================
// suset_pkg
// Shared constants, status codes and controller/datapath interface types for
// the sorted unique set.
// ============================================================================
package suset_pkg;

  // Store geometry
  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;

  // Result field widths
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // Read address source
  typedef enum logic [1:0] {
    RD_PTR,
    RD_MOV_DN,
    RD_MOV_UP
  } rd_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic                load;
    logic                ptr_inc;
    logic                hit_set;
    logic                mov_init_occ;
    logic                mov_init_ptr;
    logic                mov_dec;
    logic                mov_inc;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                wr_en;
    logic                wr_shift;
    logic                occ_inc;
    logic                occ_dec;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                res_pos_zero;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic odd;
    logic hit;
    logic scan_end;
    logic entry_ge;
    logic full;
    logic ins_end;
    logic del_end;
  } stat_t;

endpackage

### rtl/sorted_unique_set_insert_delete.sv
// ============================================================================
// sorted_unique_set_insert_delete
// Ascending set of unique signed 32-bit values with insert and delete.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / value): each transaction carries one
//   value. An odd value is inserted at its sorted place unless already
//   present or the store is full; an even value is deleted if present.
//   Output channel (out_valid / out_stall / status / position / count): one
//   result per input, in order, with the new number of stored values.
//   Sequencing: the store is one memory with a registered read. A linear
//   search reads, then compares each entry examined, and every entry shifted
//   by an insert or delete is read, then written. The next input can be taken
//   in the cycle after the result is registered.
//   Throughput: one item at a time; in_stall is high from acceptance until
//   the result is loaded into the output register.
//   Stalling: a result waits in the output register while out_stall is high;
//   the next input may already be accepted, but its result is held back until
//   the pending one has been taken.
//   Reset (rst, synchronous): empties the store and drops any pending result.
// ============================================================================
module sorted_unique_set_insert_delete (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [suset_pkg::DATA_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [suset_pkg::STATUS_W-1:0]      status,
  output logic [suset_pkg::POS_W-1:0]         position,
  output logic [suset_pkg::COUNT_W-1:0]       count
);

  suset_pkg::cmd_t  cmd;
  suset_pkg::stat_t stat;

  suset_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  suset_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .value    (value),
    .status   (status),
    .position (position),
    .count    (count)
  );

endmodule

### rtl/suset_ram.sv
// ============================================================================
// suset_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module suset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/suset_dp.sv
// ============================================================================
// suset_dp
// Datapath: value register, scan and move pointers, occupancy, the store
// memory, the signed comparator and the result registers.
// ============================================================================
module suset_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  suset_pkg::cmd_t                      cmd,
  output suset_pkg::stat_t                     stat,
  input  logic signed [suset_pkg::DATA_W-1:0]  value,
  output logic [suset_pkg::STATUS_W-1:0]       status,
  output logic [suset_pkg::POS_W-1:0]          position,
  output logic [suset_pkg::COUNT_W-1:0]        count
);

  logic signed [suset_pkg::DATA_W-1:0] val;
  logic [suset_pkg::CNT_W-1:0]         ptr;
  logic [suset_pkg::CNT_W-1:0]         mov;
  logic [suset_pkg::CNT_W-1:0]         occ;
  logic                                hit;

  logic [suset_pkg::CNT_W-1:0]         mov_dn;
  logic [suset_pkg::CNT_W-1:0]         mov_up;
  logic [suset_pkg::CNT_W-1:0]         rd_idx;
  logic [suset_pkg::ADDR_W-1:0]        rd_addr;
  logic [suset_pkg::ADDR_W-1:0]        wr_addr;
  logic [suset_pkg::DATA_W-1:0]        wr_data;
  logic [suset_pkg::DATA_W-1:0]        rd_data;

  assign mov_dn = mov - suset_pkg::CNT_W'(1);
  assign mov_up = mov + suset_pkg::CNT_W'(1);

  // Select read and write addresses
  always_comb begin
    case (cmd.rd_sel)
      suset_pkg::RD_PTR:    rd_idx = ptr;
      suset_pkg::RD_MOV_DN: rd_idx = mov_dn;
      suset_pkg::RD_MOV_UP: rd_idx = mov_up;
      default:              rd_idx = ptr;
    endcase
  end

  assign rd_addr = rd_idx[suset_pkg::ADDR_W-1:0];
  assign wr_addr = cmd.wr_shift ? mov[suset_pkg::ADDR_W-1:0] : ptr[suset_pkg::ADDR_W-1:0];
  assign wr_data = cmd.wr_shift ? rd_data : val;

  suset_ram #(
    .WIDTH (suset_pkg::DATA_W),
    .DEPTH (suset_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold the value, the pointers and the hit flag
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= value;
    end
    if (cmd.load) begin
      ptr <= '0;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + suset_pkg::CNT_W'(1);
    end
    if (cmd.mov_init_occ) begin
      mov <= occ;
    end else if (cmd.mov_init_ptr) begin
      mov <= ptr;
    end else if (cmd.mov_dec) begin
      mov <= mov_dn;
    end else if (cmd.mov_inc) begin
      mov <= mov_up;
    end
    if (cmd.load) begin
      hit <= 1'b0;
    end else if (cmd.hit_set) begin
      hit <= (rd_data == val);
    end
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.occ_inc) begin
      occ <= occ + suset_pkg::CNT_W'(1);
    end else if (cmd.occ_dec) begin
      occ <= occ - suset_pkg::CNT_W'(1);
    end
  end

  // Capture the result transaction
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status   <= cmd.res_status;
      position <= cmd.res_pos_zero ? '0 : suset_pkg::POS_W'(ptr);
      count    <= suset_pkg::COUNT_W'(occ);
    end
  end

  // Report status to the controller
  assign stat.odd      = val[0];
  assign stat.hit      = hit;
  assign stat.scan_end = (ptr == occ);
  assign stat.entry_ge = ($signed(rd_data) >= val);
  assign stat.full     = (occ == suset_pkg::CNT_W'(suset_pkg::DEPTH));
  assign stat.ins_end  = (mov == ptr);
  assign stat.del_end  = (mov_up == occ);

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= suset_pkg::CNT_W'(suset_pkg::DEPTH))
    else $error("occupancy beyond store depth");

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.occ_inc |-> (occ < suset_pkg::CNT_W'(suset_pkg::DEPTH)))
    else $error("insert into a full store");

  a_del_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.occ_dec |-> (occ != '0))
    else $error("delete from an empty store");

endmodule

### rtl/suset_ctrl.sv
// ============================================================================
// suset_ctrl
// Controller: sequences the linear search, the shift for insert or delete,
// and the input and result handshakes.
// ============================================================================
module suset_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  suset_pkg::stat_t stat,
  output suset_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_FINISH
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [suset_pkg::STATUS_W-1:0] res_status;
  logic [suset_pkg::STATUS_W-1:0] res_status_next;
  logic                          pos_zero;
  logic                          pos_zero_next;
  logic                          out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Decode state into datapath commands
  always_comb begin
    cmd              = '0;
    cmd.rd_sel       = suset_pkg::RD_PTR;
    cmd.res_status   = res_status;
    cmd.res_pos_zero = pos_zero;
    state_next       = state;
    res_status_next  = res_status;
    pos_zero_next    = pos_zero;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          state_next = S_DECIDE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.entry_ge) begin
          cmd.hit_set = 1'b1;
          state_next  = S_DECIDE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_DECIDE: begin
        pos_zero_next = 1'b0;
        if (stat.odd) begin
          if (stat.hit) begin
            res_status_next = suset_pkg::ST_DUPLICATE;
            state_next      = S_FINISH;
          end else if (stat.full) begin
            res_status_next = suset_pkg::ST_FULL;
            pos_zero_next   = 1'b1;
            state_next      = S_FINISH;
          end else begin
            res_status_next  = suset_pkg::ST_INSERTED;
            cmd.mov_init_occ = 1'b1;
            state_next       = S_INS_RD;
          end
        end else begin
          if (stat.hit) begin
            res_status_next  = suset_pkg::ST_DELETED;
            cmd.mov_init_ptr = 1'b1;
            state_next       = S_DEL_RD;
          end else begin
            res_status_next = suset_pkg::ST_NOT_FOUND;
            pos_zero_next   = 1'b1;
            state_next      = S_FINISH;
          end
        end
      end
      S_INS_RD: begin
        if (stat.ins_end) begin
          cmd.wr_en   = 1'b1;
          cmd.occ_inc = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = suset_pkg::RD_MOV_DN;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.mov_dec  = 1'b1;
        state_next   = S_INS_RD;
      end
      S_DEL_RD: begin
        if (stat.del_end) begin
          cmd.occ_dec = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = suset_pkg::RD_MOV_UP;
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.mov_inc  = 1'b1;
        state_next   = S_DEL_RD;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      res_status <= suset_pkg::ST_INSERTED;
      pos_zero   <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      pos_zero   <= pos_zero_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_single_access: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_en && cmd.wr_en))
    else $error("store read and written in one cycle");

endmodule

### tb/suset_result_checker.sv
// ============================================================================
// suset_result_checker
// Watches both channels of the sorted unique set. Every accepted input
// transaction is run through a behavioural copy of the set to form the
// expected result, and every accepted output transaction is compared field by
// field with the oldest expected result. Mismatches are counted and handed up.
// ============================================================================
module suset_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [suset_pkg::DATA_W-1:0] value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [suset_pkg::STATUS_W-1:0]      status,
  input  logic [suset_pkg::POS_W-1:0]         position,
  input  logic [suset_pkg::COUNT_W-1:0]       count,
  output int                                  fail_count,
  output int                                  backlog
);

  typedef struct packed {
    logic [suset_pkg::STATUS_W-1:0] status;
    logic [suset_pkg::POS_W-1:0]    position;
    logic [suset_pkg::COUNT_W-1:0]  count;
  } set_result_t;

  // Shadow copy of the set: ascending values in entries 0 .. members-1
  logic signed [suset_pkg::DATA_W-1:0] shadow_set [suset_pkg::DEPTH];
  int                                  members;
  set_result_t                         expected_results [$];
  int                                  mismatches;

  initial begin
    fail_count = 0;
    backlog    = 0;
    members    = 0;
    mismatches = 0;
  end

  // Apply one value to the shadow set and return the result it should give
  function automatic set_result_t apply_value(logic signed [suset_pkg::DATA_W-1:0] v);
    int          slot;
    bit          present;
    set_result_t r;
    slot = 0;
    while (slot < members && shadow_set[slot] < v) slot++;
    present    = (slot < members) && (shadow_set[slot] == v);
    r.position = '0;
    if (v[0]) begin
      // Odd: insert unless already present or the store is full
      if (present) begin
        r.status   = suset_pkg::ST_DUPLICATE;
        r.position = slot[suset_pkg::POS_W-1:0];
      end else if (members >= suset_pkg::DEPTH) begin
        r.status = suset_pkg::ST_FULL;
      end else begin
        for (int j = members; j > slot; j--) shadow_set[j] = shadow_set[j-1];
        shadow_set[slot] = v;
        members++;
        r.status   = suset_pkg::ST_INSERTED;
        r.position = slot[suset_pkg::POS_W-1:0];
      end
    end else begin
      // Even: delete when present
      if (present) begin
        for (int j = slot; j + 1 < members; j++) shadow_set[j] = shadow_set[j+1];
        members--;
        r.status   = suset_pkg::ST_DELETED;
        r.position = slot[suset_pkg::POS_W-1:0];
      end else begin
        r.status = suset_pkg::ST_NOT_FOUND;
      end
    end
    r.count = members[suset_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Compare results first, then queue the prediction for a new input
  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      expected_results.delete();
      members = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expected result waiting");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
          end
          if (position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position);
            mismatches++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, count);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_value(value));
    end
    fail_count <= mismatches;
    backlog    <= expected_results.size();
  end

endmodule

### tb/testbench.sv
// ============================================================================
// testbench
// Drives the sorted unique set with a directed opening of extreme and special
// values, then with random values drawn mostly from narrow pools so that
// duplicates, misses and a full store all occur. Both channels idle at random
// apart from one calm stretch. The checker beside the block does the
// prediction and comparison; this module gives the verdict.
// ============================================================================
module testbench;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 4 * suset_pkg::DEPTH + 40;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  logic signed [suset_pkg::DATA_W-1:0] value     = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [suset_pkg::STATUS_W-1:0]      status;
  logic [suset_pkg::POS_W-1:0]         position;
  logic [suset_pkg::COUNT_W-1:0]       count;
  logic                                calm      = 1'b0;
  int                                  fail_count;
  int                                  backlog;
  int                                  cycles    = 0;

  int opening_values [19] = '{
    32'h80000000, 32'h00000001, 32'h00000001, 32'h7FFFFFFF, 32'h80000001,
    32'hFFFFFFFF, 32'h00000003, 32'h00000000, 32'h00000002, 32'hFFFFFFFE,
    32'h80000000, 32'h7FFFFFFE, 32'h55555555, 32'hAAAAAAAB, 32'hFFFFFFFF,
    32'h7FFFFFFF, 32'h80000001, 32'h00000005, 32'hAAAAAAAA
  };

  sorted_unique_set_insert_delete u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .position  (position),
    .count     (count)
  );

  suset_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .position   (position),
    .count      (count),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random outside the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 9);
  end

  // Give up after a generous number of cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one value, with random idle cycles first, and hold it until taken
  task automatic offer_value(input logic signed [suset_pkg::DATA_W-1:0] v);
    while (!calm && ($urandom_range(0, 99) < 9)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Draw a random value: mostly narrow pools, some wide and extreme ones
  function automatic logic signed [suset_pkg::DATA_W-1:0] pick_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return int'($urandom_range(0, 99)) * 2 - 99;
    else if (pick < 75) return int'($urandom_range(0, 100)) * 2 - 100;
    else if (pick < 85) return $urandom() | 32'h1;
    else if (pick < 95) return $urandom();
    else begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFFFFFF;
        1:       return 32'h80000001;
        2:       return 32'h80000000;
        default: return 32'h7FFFFFFE;
      endcase
    end
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: extremes, duplicates, misses, head and tail inserts
    foreach (opening_values[k]) offer_value(opening_values[k]);

    // Random part with one long calm stretch in the middle
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 500) && (n < 800);
      offer_value(pick_value());
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // Drain outstanding results, then allow for one more item time
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/suset_pkg.sv
rtl/suset_ram.sv
rtl/suset_dp.sv
rtl/suset_ctrl.sv
rtl/sorted_unique_set_insert_delete.sv
tb/suset_result_checker.sv
tb/testbench.sv
